// ===== hw/rtl/rlpt_pkg.sv =====
// ----------------------------------------------------------------------------
// rlpt_pkg
// Shared types, codes and limits of the region latency profiler table.
// ----------------------------------------------------------------------------
`default_nettype none

package rlpt_pkg;

   localparam int DEF_ENTRIES   = 64;
   localparam int DEF_TIME_BITS = 48;
   localparam int IDX_MAX_W     = 10;   // enough for the largest table
   localparam int TIME_MAX_W    = 64;   // widest time counter

   localparam logic [1:0] KIND_BEGIN = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_RESET = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_NESTED  = 3'd2;
   localparam logic [2:0] ST_NOMATCH = 3'd3;
   localparam logic [2:0] ST_NOTRUN  = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] region_tag;
      logic [31:0] thread_ident;
      logic [47:0] timestamp;
      logic [5:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  entry_index;
      logic        entry_valid;
      logic [15:0] entry_tag;
      logic [31:0] entry_thread;
      logic [63:0] total_ticks;
      logic [47:0] least_ticks;
      logic [47:0] second_least_ticks;
      logic [47:0] greatest_ticks;
      logic [47:0] second_greatest_ticks;
      logic [31:0] completed_calls;
   } rsp_type;

   // work for the statistics side
   typedef enum logic [2:0] {
      OP_BEGIN_NEW,   // claim: clear stats, record start
      OP_BEGIN,       // record start
      OP_END,         // fold duration into stats
      OP_REPORT,      // report entry, no write
      OP_BLANK        // report zeros
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [2:0]              status;
      logic [IDX_MAX_W-1:0]    idx;
      logic [5:0]              out_index;
      logic                    used;
      logic [15:0]             tag;
      logic [31:0]             owner;
      logic [TIME_MAX_W-1:0]   now;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rlpt_queue.sv =====
// ----------------------------------------------------------------------------
// rlpt_queue
// Two-entry command queue between the front and the statistics back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpt_queue import rlpt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         not_empty,
   output cmd_type      head
);

   cmd_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop  ? ~rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rlpt_front.sv =====
// ----------------------------------------------------------------------------
// rlpt_front
// Takes events, searches the key table and issues commands to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpt_front import rlpt_pkg::*; #(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         push,
   output cmd_type      push_cmd,
   input  wire logic    q_full
);

   localparam int IdxW = $clog2(ENTRIES);

   typedef enum logic [1:0] {F_IDLE, F_MATCH, F_PUSH} fstate_type;

   fstate_type           state_ff;
   req_type              item_ff;
   logic [ENTRIES-1:0]   used_ff, running_ff;
   logic [15:0]          tag_ff   [ENTRIES];
   logic [31:0]          owner_ff [ENTRIES];
   logic [ENTRIES-1:0]   cand_ff, hit_ff;

   logic [ENTRIES-1:0]   hit_in;
   logic                 cand_any, hit_any;
   logic [IdxW-1:0]      cand_idx, hit_idx, rd_idx;
   logic                 rd_oor;
   cmd_type              cmd_in;
   logic                 do_claim, do_run, do_stop, do_clear;
   logic [IdxW-1:0]      upd_idx;

   assign req_stall = (state_ff != F_IDLE);
   assign push      = (state_ff == F_PUSH) && !q_full;
   assign push_cmd  = cmd_in;

   // key compare, one per entry
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_in[i] = used_ff[i] && (tag_ff[i] == item_ff.region_tag)
                     && (owner_ff[i] == item_ff.thread_ident);
      end
   end

   // lowest set bit wins
   always_comb begin
      cand_any = 1'b0;
      cand_idx = '0;
      hit_any  = 1'b0;
      hit_idx  = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (cand_ff[i]) begin
            cand_any = 1'b1;
            cand_idx = IdxW'(i);
         end
         if (hit_ff[i]) begin
            hit_any = 1'b1;
            hit_idx = IdxW'(i);
         end
      end
   end

   assign rd_oor = ({26'd0, item_ff.read_index} >= 32'(ENTRIES));
   assign rd_idx = IdxW'(item_ff.read_index);

   always_comb begin
      cmd_in           = '0;
      cmd_in.op        = OP_BLANK;
      cmd_in.status    = ST_OK;
      cmd_in.now       = TIME_MAX_W'(item_ff.timestamp);
      do_claim         = 1'b0;
      do_run           = 1'b0;
      do_stop          = 1'b0;
      do_clear         = 1'b0;
      upd_idx          = '0;
      unique case (item_ff.kind)
         KIND_BEGIN: begin
            upd_idx = cand_idx;
            if (!cand_any) begin
               cmd_in.status = ST_FULL;
            end else begin
               cmd_in.idx       = IDX_MAX_W'(cand_idx);
               cmd_in.out_index = 6'(cand_idx);
               cmd_in.used      = 1'b1;
               cmd_in.tag       = item_ff.region_tag;
               cmd_in.owner     = item_ff.thread_ident;
               if (!used_ff[cand_idx]) begin
                  cmd_in.op = OP_BEGIN_NEW;
                  do_claim  = 1'b1;
                  do_run    = 1'b1;
               end else if (running_ff[cand_idx]) begin
                  cmd_in.op     = OP_REPORT;
                  cmd_in.status = ST_NESTED;
               end else begin
                  cmd_in.op = OP_BEGIN;
                  do_run    = 1'b1;
               end
            end
         end
         KIND_END: begin
            upd_idx = hit_idx;
            if (!hit_any) begin
               cmd_in.status = ST_NOMATCH;
            end else begin
               cmd_in.idx       = IDX_MAX_W'(hit_idx);
               cmd_in.out_index = 6'(hit_idx);
               cmd_in.used      = 1'b1;
               cmd_in.tag       = item_ff.region_tag;
               cmd_in.owner     = item_ff.thread_ident;
               if (running_ff[hit_idx]) begin
                  cmd_in.op = OP_END;
                  do_stop   = 1'b1;
               end else begin
                  cmd_in.op     = OP_REPORT;
                  cmd_in.status = ST_NOTRUN;
               end
            end
         end
         KIND_RESET: begin
            cmd_in.op = OP_REPORT;
            do_clear  = 1'b1;
         end
         default: begin
            cmd_in.out_index = item_ff.read_index;
            if (rd_oor) begin
               cmd_in.status = ST_NOMATCH;
            end else begin
               cmd_in.op    = OP_REPORT;
               cmd_in.idx   = IDX_MAX_W'(rd_idx);
               cmd_in.used  = used_ff[rd_idx];
               cmd_in.tag   = used_ff[rd_idx] ? tag_ff[rd_idx]   : 16'd0;
               cmd_in.owner = used_ff[rd_idx] ? owner_ff[rd_idx] : 32'd0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         used_ff    <= '0;
         running_ff <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  state_ff <= F_MATCH;
               end
            end
            F_MATCH: begin
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (!q_full) begin
                  state_ff <= F_IDLE;
                  if (do_clear) begin
                     used_ff    <= '0;
                     running_ff <= '0;
                  end
                  if (do_claim) begin
                     used_ff[upd_idx] <= 1'b1;
                  end
                  if (do_run) begin
                     running_ff[upd_idx] <= 1'b1;
                  end
                  if (do_stop) begin
                     running_ff[upd_idx] <= 1'b0;
                  end
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_valid) begin
         item_ff <= req_data;
      end
      if (state_ff == F_MATCH) begin
         hit_ff  <= hit_in;
         cand_ff <= hit_in | ~used_ff;
      end
      if (push && do_claim) begin
         tag_ff[upd_idx]   <= item_ff.region_tag;
         owner_ff[upd_idx] <= item_ff.thread_ident;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rlpt_back.sv =====
// ----------------------------------------------------------------------------
// rlpt_back
// Statistics memory: read-modify-write per command, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpt_back import rlpt_pkg::*; #(
   parameter int ENTRIES   = DEF_ENTRIES,
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire cmd_type q_cmd,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IdxW = $clog2(ENTRIES);

   typedef struct packed {
      logic [TIME_BITS-1:0] start;
      logic [63:0]          sum;
      logic [TIME_BITS-1:0] lo0;
      logic [TIME_BITS-1:0] lo1;
      logic [TIME_BITS-1:0] hi0;
      logic [TIME_BITS-1:0] hi1;
      logic [31:0]          cnt;
   } rec_type;

   typedef enum logic [1:0] {B_IDLE, B_DIFF, B_UPD} bstate_type;

   rec_type              mem [ENTRIES];
   bstate_type           state_ff;
   cmd_type              cmd_ff;
   rec_type              rd_ff;
   logic [TIME_BITS-1:0] dur_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic [TIME_BITS-1:0] now_t;
   rec_type              rec_new, rec_rst, rec_out;
   logic [64:0]          sum_wide;
   logic                 slot_free, do_write;
   rsp_type              rsp_in;

   assign pop       = (state_ff == B_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign now_t     = cmd_ff.now[TIME_BITS-1:0];
   assign do_write  = (state_ff == B_UPD) && slot_free
                      && (cmd_ff.op == OP_BEGIN_NEW || cmd_ff.op == OP_BEGIN
                          || cmd_ff.op == OP_END);

   always_comb begin
      rec_rst       = '0;
      rec_rst.lo0   = '1;
      rec_rst.lo1   = '1;
      sum_wide      = {1'b0, rd_ff.sum} + 65'(dur_ff);
      rec_new       = rd_ff;
      case (cmd_ff.op)
         OP_BEGIN_NEW: begin
            rec_new       = rec_rst;
            rec_new.start = now_t;
         end
         OP_BEGIN: begin
            rec_new.start = now_t;
         end
         OP_END: begin
            rec_new.start = '0;
            if (dur_ff < rd_ff.lo0) begin
               rec_new.lo1 = rd_ff.lo0;
               rec_new.lo0 = dur_ff;
            end else if (dur_ff < rd_ff.lo1) begin
               rec_new.lo1 = dur_ff;
            end
            if (dur_ff > rd_ff.hi0) begin
               rec_new.hi1 = rd_ff.hi0;
               rec_new.hi0 = dur_ff;
            end else if (dur_ff > rd_ff.hi1) begin
               rec_new.hi1 = dur_ff;
            end
            rec_new.sum = sum_wide[64] ? '1 : sum_wide[63:0];
            rec_new.cnt = (rd_ff.cnt == '1) ? rd_ff.cnt : rd_ff.cnt + 32'd1;
         end
         default: ;
      endcase
      if (cmd_ff.op == OP_BLANK) begin
         rec_out = '0;
      end else if (!cmd_ff.used) begin
         rec_out = rec_rst;
      end else begin
         rec_out = rec_new;
      end
      rsp_in.status                = cmd_ff.status;
      rsp_in.entry_index           = cmd_ff.out_index;
      rsp_in.entry_valid           = cmd_ff.used;
      rsp_in.entry_tag             = cmd_ff.tag;
      rsp_in.entry_thread          = cmd_ff.owner;
      rsp_in.total_ticks           = rec_out.sum;
      rsp_in.least_ticks           = 48'(rec_out.lo0);
      rsp_in.second_least_ticks    = 48'(rec_out.lo1);
      rsp_in.greatest_ticks        = 48'(rec_out.hi0);
      rsp_in.second_greatest_ticks = 48'(rec_out.hi1);
      rsp_in.completed_calls       = rec_out.cnt;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff <= mem[q_cmd.idx[IdxW-1:0]];
      end
      if (do_write) begin
         mem[cmd_ff.idx[IdxW-1:0]] <= rec_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (q_valid) begin
                  cmd_ff   <= q_cmd;
                  state_ff <= B_DIFF;
               end
            end
            B_DIFF: begin
               dur_ff   <= now_t - rd_ff.start;
               state_ff <= B_UPD;
            end
            B_UPD: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= rsp_in;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/region_latency_profiler_table_core.sv =====
// ----------------------------------------------------------------------------
// region_latency_profiler_table_core
// Table of timed regions keyed by region tag and thread, with per-entry
// duration statistics.
// ----------------------------------------------------------------------------
// Usage notes
//  - req_*: one event per transfer (begin, end, reset table, read entry).
//  - rsp_*: exactly one result transfer per event, in event order.
//  - Front end: per event, capture, parallel key compare into a registered
//    hit vector, then priority pick and key/run-bit update, held while the
//    queue is full. It then hands a command to a two-entry queue.
//  - Back end: per command, statistics memory read, duration subtract, then
//    min/max/sum update with write-back and result load, held on rsp_stall.
//  - Neither end takes a new event before it is through with the last: the
//    front end raises req_stall for its compare-then-pick sequence, and the
//    back end pops only after the read-modify-write of the single statistics
//    port. rsp_valid rises when the back end loads the result register.
//  - Reset: table empty straight away (used and running bits cleared);
//    statistics of unused entries read as cleared values, so no sweep.
//  - rsp_stall holds the result register; the back end waits, the queue
//    fills, and then req_stall stays high until room appears.
// ----------------------------------------------------------------------------
`default_nettype none

module region_latency_profiler_table_core import rlpt_pkg::*; #(
   parameter int ENTRIES   = DEF_ENTRIES,
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    push, q_full, pop, q_valid;
   cmd_type push_cmd, q_head;

   // search and key ownership
   rlpt_front #(.ENTRIES(ENTRIES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_cmd  (push_cmd),
      .q_full    (q_full)
   );

   // decouples search from statistics update
   rlpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   // statistics memory and result register
   rlpt_back #(.ENTRIES(ENTRIES), .TIME_BITS(TIME_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // blank results never report a live entry
   a_blank_not_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FULL || rsp_data.status == ST_NOMATCH)
      |-> !rsp_data.entry_valid)
      else $error("blank result reports a valid entry");

   // the two smallest stay ordered
   a_least_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.least_ticks <= rsp_data.second_least_ticks)
      else $error("least durations out of order");

   // the two largest stay ordered
   a_greatest_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.greatest_ticks >= rsp_data.second_greatest_ticks)
      else $error("greatest durations out of order");

   // no result without a preceding event in flight
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pop, 3) || $past(rsp_valid))
      else $error("result without a queued command");

endmodule

`default_nettype wire

// ===== tb/rlpt_checker.sv =====
// ----------------------------------------------------------------------------
// rlpt_checker
// Watches both channels, models the profiler table and compares each result.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpt_checker import rlpt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N = DEF_ENTRIES;
   localparam logic [47:0] ONES48 = '1;

   logic        in_use  [N];
   logic        running [N];
   logic [15:0] tags    [N];
   logic [31:0] owners  [N];
   logic [47:0] starts  [N];
   logic [63:0] sums    [N];
   logic [47:0] lo0 [N], lo1 [N], hi0 [N], hi1 [N];
   logic [31:0] calls   [N];
   rsp_type     expected_results[$];

   function automatic void clear_stats(int e);
      sums[e] = '0; lo0[e] = ONES48; lo1[e] = ONES48;
      hi0[e] = '0; hi1[e] = '0; calls[e] = '0;
   endfunction

   function automatic void clear_table();
      for (int e = 0; e < N; e++) begin
         in_use[e] = 0; running[e] = 0; tags[e] = '0; owners[e] = '0;
         starts[e] = '0; clear_stats(e);
      end
   endfunction

   function automatic rsp_type report_entry(logic [2:0] st, int e);
      rsp_type r;
      r.status = st; r.entry_index = e[5:0]; r.entry_valid = in_use[e];
      r.entry_tag = tags[e]; r.entry_thread = owners[e]; r.total_ticks = sums[e];
      r.least_ticks = lo0[e]; r.second_least_ticks = lo1[e];
      r.greatest_ticks = hi0[e]; r.second_greatest_ticks = hi1[e];
      r.completed_calls = calls[e];
      return r;
   endfunction

   function automatic rsp_type blank(logic [2:0] st, logic [5:0] idx);
      rsp_type r;
      r = '0; r.status = st; r.entry_index = idx;
      return r;
   endfunction

   function automatic rsp_type apply_event(req_type q);
      logic [47:0] d;
      logic [64:0] s;
      case (q.kind)
         KIND_BEGIN: begin
            for (int e = 0; e < N; e++) begin
               if (in_use[e] && tags[e] == q.region_tag && owners[e] == q.thread_ident) begin
                  if (running[e]) return report_entry(ST_NESTED, e);
                  starts[e] = q.timestamp; running[e] = 1;
                  return report_entry(ST_OK, e);
               end
               if (!in_use[e]) begin
                  in_use[e] = 1; tags[e] = q.region_tag; owners[e] = q.thread_ident;
                  clear_stats(e); starts[e] = q.timestamp; running[e] = 1;
                  return report_entry(ST_OK, e);
               end
            end
            return blank(ST_FULL, '0);
         end
         KIND_END: begin
            for (int e = 0; e < N; e++) begin
               if (in_use[e] && tags[e] == q.region_tag && owners[e] == q.thread_ident) begin
                  if (!running[e]) return report_entry(ST_NOTRUN, e);
                  d = q.timestamp - starts[e];
                  if (d < lo0[e]) begin lo1[e] = lo0[e]; lo0[e] = d; end
                  else if (d < lo1[e]) lo1[e] = d;
                  if (d > hi0[e]) begin hi1[e] = hi0[e]; hi0[e] = d; end
                  else if (d > hi1[e]) hi1[e] = d;
                  s = {1'b0, sums[e]} + d;
                  sums[e] = s[64] ? '1 : s[63:0];
                  if (calls[e] != '1) calls[e] = calls[e] + 1;
                  starts[e] = '0; running[e] = 0;
                  return report_entry(ST_OK, e);
               end
            end
            return blank(ST_NOMATCH, '0);
         end
         KIND_RESET: begin
            clear_table();
            return report_entry(ST_OK, 0);
         end
         default: return report_entry(ST_OK, q.read_index);
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;
   initial pending_count = 0;

   always @(posedge clock) begin
      rsp_type w;
      if (reset) begin
         clear_table();
         expected_results.delete();
      end else begin
         // result first, so an expectation queued this edge cannot match it
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_data.status, 0);
            end else begin
               w = expected_results.pop_front();
               if (rsp_data.status != w.status)
                  report_mismatch("status", rsp_data.status, w.status);
               if (rsp_data.entry_index != w.entry_index)
                  report_mismatch("entry_index", rsp_data.entry_index, w.entry_index);
               if (rsp_data.entry_valid != w.entry_valid)
                  report_mismatch("entry_valid", rsp_data.entry_valid, w.entry_valid);
               if (rsp_data.entry_tag != w.entry_tag)
                  report_mismatch("entry_tag", rsp_data.entry_tag, w.entry_tag);
               if (rsp_data.entry_thread != w.entry_thread)
                  report_mismatch("entry_thread", rsp_data.entry_thread, w.entry_thread);
               if (rsp_data.total_ticks != w.total_ticks)
                  report_mismatch("total_ticks", rsp_data.total_ticks, w.total_ticks);
               if (rsp_data.least_ticks != w.least_ticks)
                  report_mismatch("least_ticks", rsp_data.least_ticks, w.least_ticks);
               if (rsp_data.second_least_ticks != w.second_least_ticks)
                  report_mismatch("second_least_ticks", rsp_data.second_least_ticks,
                                  w.second_least_ticks);
               if (rsp_data.greatest_ticks != w.greatest_ticks)
                  report_mismatch("greatest_ticks", rsp_data.greatest_ticks,
                                  w.greatest_ticks);
               if (rsp_data.second_greatest_ticks != w.second_greatest_ticks)
                  report_mismatch("second_greatest_ticks", rsp_data.second_greatest_ticks,
                                  w.second_greatest_ticks);
               if (rsp_data.completed_calls != w.completed_calls)
                  report_mismatch("completed_calls", rsp_data.completed_calls,
                                  w.completed_calls);
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(apply_event(req_data));
      end
      pending_count = expected_results.size();
   end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives begin/end/reset/read events into the profiler table with random
// gaps and result back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import rlpt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   // idling and back-pressure are off for a stretch mid random part
   bit      steady;

   // small pools of keys so begins and ends actually meet
   logic [15:0] tag_pool [4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001};
   logic [31:0] thr_pool [4] = '{32'h0, 32'hFFFF_FFFF, 32'hA5A5_0001, 32'h7};
   logic [47:0] clock_now;

   region_latency_profiler_table_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rlpt_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // receiver back-pressure: about 36 percent stall chance, none while steady
   initial rsp_stall = 0;
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 36);
   end

   // Present one event and hold it until the transfer; idle gaps come first
   // so valid stays up across back-to-back transfers.
   task automatic send_event(req_type q);
      while (!steady && $urandom_range(99) < 36) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= q;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_kind(logic [1:0] k, int ti, int hi, logic [47:0] ts,
                            logic [5:0] ri);
      req_type q;
      q.kind = k; q.region_tag = tag_pool[ti]; q.thread_ident = thr_pool[hi];
      q.timestamp = ts; q.read_index = ri;
      send_event(q);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      req_type q;
      int r;
      reset     = 1;
      req_valid = 0;
      req_data  = '0;
      steady    = 0;
      clock_now = '0;
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed: extremes, every kind and each error status
      send_kind(KIND_READ,  0, 0, '0, 6'd0);
      send_kind(KIND_END,   0, 0, '0, 6'd0);          // end with nothing matching
      send_kind(KIND_BEGIN, 1, 1, '1, 6'd63);         // start at the top of time
      send_kind(KIND_BEGIN, 1, 1, 48'd5, 6'd0);       // nested begin
      send_kind(KIND_END,   1, 1, 48'd9, 6'd0);       // elapsed time wraps round
      send_kind(KIND_END,   1, 1, 48'd20, 6'd0);      // end while not running
      send_kind(KIND_BEGIN, 1, 1, 48'd100, 6'd0);
      send_kind(KIND_END,   1, 1, '1, 6'd0);          // near-maximum duration
      send_kind(KIND_BEGIN, 1, 1, 48'd0, 6'd0);
      send_kind(KIND_END,   1, 1, 48'd0, 6'd0);       // zero duration
      send_kind(KIND_BEGIN, 1, 1, 48'd0, 6'd0);
      send_kind(KIND_END,   1, 1, 48'd3, 6'd0);
      send_kind(KIND_READ,  0, 0, '0, 6'd63);
      send_kind(KIND_READ,  0, 0, '0, 6'd0);
      // total saturation: two maximal spans overflow nothing, nor does the
      // random part; fill the table to reach the full status
      for (int i = 0; i < 65; i++) begin
         q = '0; q.kind = KIND_BEGIN; q.region_tag = i[15:0] + 16'h4000;
         q.thread_ident = 32'hFFFF_FFFF; q.timestamp = 48'h8000_0000_0000;
         send_event(q);
      end
      send_kind(KIND_READ,  0, 0, '0, 6'd62);
      send_kind(KIND_RESET, 0, 0, '0, 6'd0);
      drain();   // sender holds off until every result is back

      // random: mostly begins and ends over a small key set
      for (int i = 0; i < 1000; i++) begin
         steady = (i >= 400 && i < 550);
         clock_now = clock_now + 48'($urandom_range(1000));
         r = $urandom_range(99);
         q.region_tag   = tag_pool[$urandom_range(3)];
         q.thread_ident = thr_pool[$urandom_range(3)];
         q.timestamp    = clock_now;
         q.read_index   = 6'($urandom_range(63));
         if (r < 42)      q.kind = KIND_BEGIN;
         else if (r < 84) q.kind = KIND_END;
         else if (r < 86) q.kind = KIND_RESET;
         else             q.kind = KIND_READ;
         if (r >= 96) begin
            // noise: any key, any time and any kind
            q.region_tag   = 16'($urandom);
            q.thread_ident = $urandom;
            q.timestamp    = 48'({$urandom, $urandom});
            q.kind         = 2'($urandom_range(3));
         end
         send_event(q);
         if (i == 700) drain();
      end
      steady = 0;
      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #200000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/rlpt_pkg.sv
hw/rtl/rlpt_queue.sv
hw/rtl/rlpt_front.sv
hw/rtl/rlpt_back.sv
hw/rtl/region_latency_profiler_table_core.sv
tb/rlpt_checker.sv
tb/testbench.sv
